// ----- design/bgdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bgdc_pkg
// shared types and constants of the button gesture dimmer control
// ----------------------------------------------------------------------------
`default_nettype none

package bgdc_pkg;

   // field widths
   localparam int TICK_W   = 10;
   localparam int LEVEL_W  = 16;
   localparam int CLICK_W  = 3;
   localparam int CODE_W   = 4;
   localparam int CSR_IX_W = 3;

   // stream payload widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = LEVEL_W + 1 + CLICK_W + CODE_W;

   // register reset values
   localparam logic [TICK_W-1:0]  BURST_RESET   = 10'd70;
   localparam logic [TICK_W-1:0]  READY_RESET   = 10'd150;
   localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 10'd300;
   localparam logic [LEVEL_W-1:0] LEVEL1_RESET  = 16'd249;
   localparam logic [LEVEL_W-1:0] LEVEL2_RESET  = 16'd499;
   localparam logic [LEVEL_W-1:0] LEVEL3_RESET  = 16'd749;
   localparam logic [LEVEL_W-1:0] LEVEL4_RESET  = 16'd999;

   localparam logic [CLICK_W-1:0] MAX_CLICKS = 3'd4;

   typedef enum logic [CODE_W-1:0] {
      EV_IGNORED = 4'd0,
      EV_FIRST   = 4'd1,
      EV_FALSE   = 4'd2,
      EV_TOGGLE  = 4'd3,
      EV_EARLY   = 4'd4,
      EV_BURST   = 4'd5,
      EV_READY   = 4'd6,
      EV_TIMEOUT = 4'd7,
      EV_TICK    = 4'd8
   } event_code_type;

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_BURST_TICKS   = 3'd0,
      CSR_READY_TICKS   = 3'd1,
      CSR_TIMEOUT_TICKS = 3'd2,
      CSR_LEVEL_ONE     = 3'd3,
      CSR_LEVEL_TWO     = 3'd4,
      CSR_LEVEL_THREE   = 3'd5,
      CSR_LEVEL_FOUR    = 3'd6
   } csr_index_type;

   typedef enum logic {
      FUNC_PRESS = 1'b0,
      FUNC_TICK  = 1'b1
   } func_type;

endpackage

`default_nettype wire

// ----- design/button_gesture_dimmer_control.sv -----
// ----------------------------------------------------------------------------
// button_gesture_dimmer_control
// press and tick gesture decoder driving a four level pwm compare value
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  req_      in         req_tvalid/req_tready   tuser: func, tdata: from_own_source
//  rsp_      out        rsp_tvalid/rsp_tready   tdata: pwm_compare, breathing,
//                                               click_total, event_code
//  csr_      in         csr_valid/csr_ready     csr_index, csr_data
//
//  an item is held in the input register and is evaluated on its way
//  into the result register
//  one item per cycle is sustained while rsp_tready is high: the gesture
//  state is updated as the item moves from input to result register
//  reset clears the gesture state and loads the default thresholds and levels
//  a stalled result register holds the next item in the input register;
//  req_tready falls only when both registers are full and rsp_tready is low
//
`default_nettype none

module button_gesture_dimmer_control
   import bgdc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [0] from_own_source, rest zero
   input  wire logic                  req_tuser,   // [0] func

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [15:0] pwm_compare, [16] breathing,
                                                   // [19:17] click_total, [23:20] event_code

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IX_W-1:0]   csr_index,
   input  wire logic [LEVEL_W-1:0]    csr_data
);

   // configuration registers
   logic [TICK_W-1:0]  burst_ticks_ff, ready_ticks_ff, timeout_ticks_ff;
   logic [LEVEL_W-1:0] level_one_ff, level_two_ff, level_three_ff, level_four_ff;

   // input register
   logic     in_valid_ff;
   func_type in_func_ff;
   logic     in_own_ff;

   // gesture state
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic               window_ff, window_in;
   logic               first_ff, first_in;
   logic               burst_ff, burst_in;
   logic               ready_ff, ready_in;
   logic               breath_ff, breath_in;
   logic [CLICK_W-1:0] clicks_ff, clicks_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   // result register
   logic               out_valid_ff;
   logic [LEVEL_W-1:0] out_level_ff;
   logic               out_breath_ff;
   logic [CLICK_W-1:0] out_clicks_ff;
   event_code_type     out_code_ff;

   event_code_type     code;
   logic               advance;
   logic [TICK_W-1:0]  tick_inc;
   logic [CLICK_W-1:0] click_base;
   logic [CLICK_W-1:0] click_step;
   logic               do_click;

   // the evaluate stage moves when the result register is free or drains
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_code_ff, out_clicks_ff, out_breath_ff, out_level_ff};

   assign tick_inc = tick_ff + 1'b1;

   // next gesture state for the item in the input register
   always_comb begin
      tick_in    = tick_ff;
      window_in  = window_ff;
      first_in   = first_ff;
      burst_in   = burst_ff;
      ready_in   = ready_ff;
      breath_in  = breath_ff;
      clicks_in  = clicks_ff;
      level_in   = level_ff;
      code       = EV_IGNORED;
      click_base = clicks_ff;
      click_step = '0;
      do_click   = 1'b0;

      if (in_own_ff) begin
         if (in_func_ff == FUNC_PRESS) begin
            priority if (!first_ff) begin
               window_in = 1'b1;
               first_in  = 1'b1;
               code      = EV_FIRST;
            end else if (burst_ff) begin
               tick_in   = '0;
               window_in = 1'b0;
               first_in  = 1'b0;
               burst_in  = 1'b0;
               ready_in  = 1'b0;
               code      = EV_FALSE;
            end else if (ready_ff) begin
               tick_in    = '0;
               window_in  = 1'b0;
               first_in   = 1'b0;
               burst_in   = 1'b0;
               ready_in   = 1'b0;
               breath_in  = !breath_ff;
               click_base = '0;
               clicks_in  = '0;
               code       = EV_TOGGLE;
            end else begin
               code = EV_EARLY;
            end

            // a press that leaves burst and ready shut, while not breathing, counts as a click
            do_click   = !breath_in && !burst_in && !ready_in;
            click_step = click_base + 1'b1;
            if (do_click) begin
               clicks_in = click_step;
               unique case (click_step)
                  3'd1:    level_in = level_one_ff;
                  3'd2:    level_in = level_two_ff;
                  3'd3:    level_in = level_three_ff;
                  3'd4:    level_in = level_four_ff;
                  default: begin
                     level_in  = '0;
                     clicks_in = '0;
                  end
               endcase
            end
         end else if (window_ff) begin
            // thresholds checked in order burst, ready, timeout
            tick_in = tick_inc;
            priority if (tick_inc == burst_ticks_ff) begin
               burst_in = 1'b1;
               ready_in = 1'b0;
               code     = EV_BURST;
            end else if (tick_inc == ready_ticks_ff) begin
               burst_in = 1'b0;
               ready_in = 1'b1;
               code     = EV_READY;
            end else if (tick_inc == timeout_ticks_ff) begin
               tick_in   = '0;
               window_in = 1'b0;
               first_in  = 1'b0;
               burst_in  = 1'b0;
               ready_in  = 1'b0;
               code      = EV_TIMEOUT;
            end else begin
               code = EV_TICK;
            end
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ticks_ff   <= BURST_RESET;
         ready_ticks_ff   <= READY_RESET;
         timeout_ticks_ff <= TIMEOUT_RESET;
         level_one_ff     <= LEVEL1_RESET;
         level_two_ff     <= LEVEL2_RESET;
         level_three_ff   <= LEVEL3_RESET;
         level_four_ff    <= LEVEL4_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BURST_TICKS:   burst_ticks_ff   <= csr_data[TICK_W-1:0];
            CSR_READY_TICKS:   ready_ticks_ff   <= csr_data[TICK_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_data[TICK_W-1:0];
            CSR_LEVEL_ONE:     level_one_ff     <= csr_data;
            CSR_LEVEL_TWO:     level_two_ff     <= csr_data;
            CSR_LEVEL_THREE:   level_three_ff   <= csr_data;
            CSR_LEVEL_FOUR:    level_four_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff <= func_type'(req_tuser);
         in_own_ff  <= req_tdata[0];
      end
   end

   // gesture state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         window_ff <= 1'b0;
         first_ff  <= 1'b0;
         burst_ff  <= 1'b0;
         ready_ff  <= 1'b0;
         breath_ff <= 1'b0;
         clicks_ff <= '0;
         level_ff  <= '0;
      end else if (advance) begin
         tick_ff   <= tick_in;
         window_ff <= window_in;
         first_ff  <= first_in;
         burst_ff  <= burst_in;
         ready_ff  <= ready_in;
         breath_ff <= breath_in;
         clicks_ff <= clicks_in;
         level_ff  <= level_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_level_ff  <= level_in;
         out_breath_ff <= breath_in;
         out_clicks_ff <= clicks_in;
         out_code_ff   <= code;
      end
   end

   // checks
   a_windows_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(burst_ff && ready_ff))
      else $error("burst and ready windows open together");

   a_clicks_range: assert property (@(posedge clock) disable iff (reset)
      clicks_ff <= MAX_CLICKS)
      else $error("click count above four");

   a_window_needs_first: assert property (@(posedge clock) disable iff (reset)
      (burst_ff || ready_ff) |-> (first_ff && window_ff))
      else $error("window flag set without a running gesture");

   a_breath_no_clicks: assert property (@(posedge clock) disable iff (reset)
      breath_ff |-> (clicks_ff == '0))
      else $error("clicks counted while breathing");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("evaluated item produced no result");

endmodule

`default_nettype wire

// ----- verif/button_gesture_dimmer_control_test.sv -----
// ----------------------------------------------------------------------------
// button_gesture_dimmer_control_test
// self-checking bench for the gesture decoder and pwm level stepper
//
// press and tick items are streamed in with random bursts and gaps, results
// are drained through a receiver that stalls in changing patterns, and each
// result is checked field by field against a cycle-free model of the gesture
// state. the run walks through reset defaults, threshold and level extremes,
// and equal and reordered thresholds
// ----------------------------------------------------------------------------

module button_gesture_dimmer_control_test;
   import bgdc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400_000;
   // index with no register behind it, writes to it are dropped
   localparam logic [CSR_IX_W-1:0] CSR_UNUSED = 3'd7;

   // one press or tick item as it is queued for the driver
   typedef struct packed {
      func_type kind;
      logic     own;
   } gesture_item_type;

   // laid out msb first so the cast from rsp_tdata lands field by field
   typedef struct packed {
      event_code_type     code;
      logic [CLICK_W-1:0] clicks;
      logic               breath;
      logic [LEVEL_W-1:0] pwm;
   } lamp_result_type;

   logic                  clock;
   logic                  reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [0] from_own_source, rest zero
   logic                  req_tuser  = 1'b0; // [0] func

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [15:0] pwm_compare, [16] breathing,
                                             // [19:17] click_total, [23:20] event_code

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IX_W-1:0]   csr_index = '0;
   logic [LEVEL_W-1:0]    csr_data  = '0;

   button_gesture_dimmer_control dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // gesture model: thresholds, levels and gesture state
   // ------------------------------------------------------------------
   logic [TICK_W-1:0]  thr_burst   = BURST_RESET;
   logic [TICK_W-1:0]  thr_ready   = READY_RESET;
   logic [TICK_W-1:0]  thr_timeout = TIMEOUT_RESET;
   logic [LEVEL_W-1:0] level_tab [1:4] = '{LEVEL1_RESET, LEVEL2_RESET,
                                           LEVEL3_RESET, LEVEL4_RESET};

   logic [TICK_W-1:0]  tick_cnt    = '0;
   logic               win_run     = 1'b0;
   logic               first_seen  = 1'b0;
   logic               burst_win   = 1'b0;
   logic               ready_win   = 1'b0;
   logic               lamp_breath = 1'b0;
   logic [CLICK_W-1:0] click_cnt   = '0;
   logic [LEVEL_W-1:0] lamp_level  = '0;

   gesture_item_type pending_q [$];       // items not yet offered to the block
   lamp_result_type  lamp_results_q [$];  // results owed by the block, oldest first

   int unsigned own_items     = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;

   // window closes on false pulse, toggle and timeout
   function automatic void close_gesture();
      tick_cnt   = '0;
      first_seen = 1'b0;
      burst_win  = 1'b0;
      ready_win  = 1'b0;
      win_run    = 1'b0;
   endfunction

   function automatic lamp_result_type decode_gesture(input func_type kind, input logic own);
      lamp_result_type res;
      event_code_type  code;
      code = EV_IGNORED;
      if (own && kind == FUNC_PRESS) begin
         if (!first_seen) begin
            win_run    = 1'b1;
            first_seen = 1'b1;
            code       = EV_FIRST;
         end else if (burst_win) begin
            close_gesture();
            code = EV_FALSE;
         end else if (ready_win) begin
            close_gesture();
            lamp_breath = !lamp_breath;
            click_cnt   = '0;
            code        = EV_TOGGLE;
         end else begin
            code = EV_EARLY;
         end
         // a press that leaves both windows shut, while not breathing, steps the lamp level
         if (!lamp_breath && !burst_win && !ready_win) begin
            click_cnt = click_cnt + 1'b1;
            if (click_cnt >= 3'd1 && click_cnt <= MAX_CLICKS) begin
               lamp_level = level_tab[click_cnt];
            end else begin
               lamp_level = '0;
               click_cnt  = '0;
            end
         end
      end else if (own && win_run) begin
         tick_cnt = tick_cnt + 1'b1;
         // burst is checked first, then ready, then timeout
         if (tick_cnt == thr_burst) begin
            burst_win = 1'b1;
            ready_win = 1'b0;
            code      = EV_BURST;
         end else if (tick_cnt == thr_ready) begin
            burst_win = 1'b0;
            ready_win = 1'b1;
            code      = EV_READY;
         end else if (tick_cnt == thr_timeout) begin
            close_gesture();
            code = EV_TIMEOUT;
         end else begin
            code = EV_TICK;
         end
      end
      res.code   = code;
      res.clicks = click_cnt;
      res.breath = lamp_breath;
      res.pwm    = lamp_level;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // request driver: bursts of items separated by random gaps
   // ------------------------------------------------------------------
   int unsigned      burst_left = 1;
   int unsigned      gap_left   = 0;
   gesture_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // the item on the bus goes into the model the moment it is taken
         if (req_tvalid && req_tready) begin
            lamp_results_q.push_back(decode_gesture(func_type'(req_tuser), req_tdata[0]));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               next_item = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_item.kind;
               req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, next_item.own};
               burst_left = burst_left - 1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  // about a quarter of the bursts run straight into the next one
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result receiver: stall pattern switches between a few modes
   // ------------------------------------------------------------------
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_tready <= cycle_count[2];
         end
      endcase
   end

   // ------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------
   lamp_result_type got_result;
   lamp_result_type want_result;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result = lamp_result_type'(rsp_tdata);
         if (lamp_results_q.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_tdata);
            mismatches = mismatches + 1;
         end else begin
            want_result = lamp_results_q.pop_front();
            if (got_result.pwm !== want_result.pwm) begin
               $display("%0t: pwm_compare expected %0d actual %0d",
                        $time, want_result.pwm, got_result.pwm);
               mismatches = mismatches + 1;
            end
            if (got_result.breath !== want_result.breath) begin
               $display("%0t: breathing expected %0d actual %0d",
                        $time, want_result.breath, got_result.breath);
               mismatches = mismatches + 1;
            end
            if (got_result.clicks !== want_result.clicks) begin
               $display("%0t: click_total expected %0d actual %0d",
                        $time, want_result.clicks, got_result.clicks);
               mismatches = mismatches + 1;
            end
            if (got_result.code !== want_result.code) begin
               $display("%0t: event_code expected %0d actual %0d",
                        $time, want_result.code, got_result.code);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("button_gesture_dimmer_control regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_event(input func_type kind, input logic own);
      gesture_item_type item;
      item.kind = kind;
      item.own  = own;
      pending_q.push_back(item);
      if (own) begin
         own_items = own_items + 1;
      end
   endtask

   task automatic push_ticks(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         push_event(FUNC_TICK, 1'b1);
      end
   endtask

   // only called with nothing in flight
   task automatic write_reg(input logic [CSR_IX_W-1:0] ix, input logic [LEVEL_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= ix;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (ix)
         CSR_BURST_TICKS:   thr_burst    = val[TICK_W-1:0];
         CSR_READY_TICKS:   thr_ready    = val[TICK_W-1:0];
         CSR_TIMEOUT_TICKS: thr_timeout  = val[TICK_W-1:0];
         CSR_LEVEL_ONE:     level_tab[1] = val;
         CSR_LEVEL_TWO:     level_tab[2] = val;
         CSR_LEVEL_THREE:   level_tab[3] = val;
         CSR_LEVEL_FOUR:    level_tab[4] = val;
         default: ;
      endcase
   endtask

   // threshold registers keep only ten bits, so the upper bits carry noise
   task automatic set_thresholds(input logic [TICK_W-1:0] b, input logic [TICK_W-1:0] r,
                                 input logic [TICK_W-1:0] t);
      logic [LEVEL_W-1:0] d;
      d = LEVEL_W'($urandom);
      d[TICK_W-1:0] = b;
      write_reg(CSR_BURST_TICKS, d);
      d = LEVEL_W'($urandom);
      d[TICK_W-1:0] = r;
      write_reg(CSR_READY_TICKS, d);
      d = LEVEL_W'($urandom);
      d[TICK_W-1:0] = t;
      write_reg(CSR_TIMEOUT_TICKS, d);
   endtask

   task automatic set_levels(input logic [LEVEL_W-1:0] l1, input logic [LEVEL_W-1:0] l2,
                             input logic [LEVEL_W-1:0] l3, input logic [LEVEL_W-1:0] l4);
      write_reg(CSR_LEVEL_ONE, l1);
      write_reg(CSR_LEVEL_TWO, l2);
      write_reg(CSR_LEVEL_THREE, l3);
      write_reg(CSR_LEVEL_FOUR, l4);
   endtask

   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   // mostly ordered small thresholds, sometimes equal or shuffled ones
   task automatic randomize_setup();
      logic [TICK_W-1:0] b, r, t;
      b = TICK_W'($urandom_range(1, 8));
      case ($urandom_range(0, 3))
         0: begin
            r = b;
            t = TICK_W'(b + $urandom_range(0, 6));
         end
         1: begin
            r = TICK_W'($urandom_range(1, 12));
            t = TICK_W'($urandom_range(1, 12));
         end
         default: begin
            r = TICK_W'(b + $urandom_range(1, 8));
            t = TICK_W'(r + $urandom_range(1, 8));
         end
      endcase
      set_thresholds(b, r, t);
      set_levels(pick_level(), pick_level(), pick_level(), pick_level());
   endtask

   // press, a run of ticks sprinkled with stray and extra presses, press again;
   // now and then a lone random item as noise
   task automatic run_gestures(input int unsigned budget);
      int unsigned span, k;
      own_items = 0;
      span = 32'(thr_burst);
      if (32'(thr_ready) > span) span = 32'(thr_ready);
      if (32'(thr_timeout) > span) span = 32'(thr_timeout);
      span = span + 3;
      while (own_items < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            push_event(func_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            push_event(FUNC_PRESS, 1'b1);
            k = $urandom_range(0, span);
            for (int unsigned i = 0; i < k; i++) begin
               if ($urandom_range(0, 11) == 0) begin
                  push_event(func_type'($urandom_range(0, 1)), 1'b0);
               end
               if ($urandom_range(0, 15) == 0) begin
                  push_event(FUNC_PRESS, 1'b1);
               end
               push_event(FUNC_TICK, 1'b1);
            end
            push_event(FUNC_PRESS, 1'b1);
         end
      end
   endtask

   // everything sent and every result back, then a pause to settle
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_tvalid || lamp_results_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: foreign items, tick while stopped, click stepping and wrap
      push_event(FUNC_PRESS, 1'b0);
      push_event(FUNC_TICK, 1'b0);
      push_event(FUNC_TICK, 1'b1);
      push_event(FUNC_PRESS, 1'b1);
      repeat (4) push_event(FUNC_PRESS, 1'b1);
      // one full window on the default counts: burst, ready, then timeout
      push_ticks(300);
      push_event(FUNC_PRESS, 1'b1);
      wait_idle();

      // smallest thresholds and extreme levels, plus a write to an empty index
      set_thresholds(10'd1, 10'd2, 10'd3);
      set_levels('0, '1, '0, '1);
      write_reg(CSR_UNUSED, LEVEL_W'($urandom));
      run_gestures(150);
      wait_idle();

      // burst and ready on the same count: burst wins, ready never opens
      set_thresholds(10'd3, 10'd3, 10'd6);
      run_gestures(120);
      wait_idle();

      // ready ahead of burst
      set_thresholds(10'd6, 10'd2, 10'd9);
      run_gestures(120);
      wait_idle();

      for (int unsigned p = 0; p < 4; p++) begin
         randomize_setup();
         run_gestures(120);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("button_gesture_dimmer_control regression: pass");
      end else begin
         $display("button_gesture_dimmer_control regression: fail");
      end
      $finish;
   end

endmodule

// ----- button_gesture_dimmer_control.f -----
design/bgdc_pkg.sv
design/button_gesture_dimmer_control.sv
verif/button_gesture_dimmer_control_test.sv
